@@ design/dtnp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtnp_pkg: shared types and codes of the decimal text parser
// Parse phases, result status codes and the character codes that the
// parser recognises.
// ----------------------------------------------------------------------------
package dtnp_pkg;

  typedef enum logic [2:0] {
    PH_WS    = 3'd0,
    PH_START = 3'd1,
    PH_INT   = 3'd2,
    PH_FRAC  = 3'd3,
    PH_DONE  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_END     = 3'd0,
    ST_OTHER   = 3'd1,
    ST_INVALID = 3'd2,
    ST_LIMIT   = 3'd3,
    ST_SAT     = 3'd4
  } status_t;

  localparam logic [3:0] FRAC_DIGITS = 4'd8;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;

endpackage

@@ design/decimal_text_to_number_parser_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_text_to_number_parser_core: byte-stream decimal text to number
// Skips leading whitespace, takes one sign, digits and (in real mode) one
// dot with fraction digits, then emits a saturated signed value and status.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload (low bit up)                     handshake
//  --------  ---------  ---------------------------------------  -------------
//  s_*       in         tdata: char_code[7:0]; tuser: string_start  tvalid/tready
//  m_*       out        tdata: number_value[63:0]; tuser: parse_status[2:0]
//  cfg_*     in         cfg_wdata: real_mode                      cfg_we
//
//  One byte per cycle sustained. A byte is held in the input register, then
//  one pass through the multiply-by-ten, add and clamp logic updates the
//  parse state and, when the number ends, loads the result register as the
//  byte leaves the input register, so every result is driven from a register.
//  A byte that ends a number stalls only while the result register is full
//  and not being drained; other bytes never wait on the output side.
//  rst (synchronous) clears both registers, the parse state and real_mode.
//
module decimal_text_to_number_parser_core #(
  parameter int FRAC_BITS      = 24,
  parameter int MAX_INT_DIGITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_wdata,     // real_mode
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,       // char_code[7:0]
  input  logic        s_tuser,       // string_start
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,       // number_value[63:0] (signed)
  output logic [2:0]  m_tuser        // parse_status[2:0]
);

  // Fraction weights: round(2^FRAC_BITS / 10^k) for k = 1..8
  localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;
  localparam logic [FRAC_BITS-1:0] FRAC_W [8] = '{
    FRAC_BITS'((ONE + 64'd5)        / 64'd10),
    FRAC_BITS'((ONE + 64'd50)       / 64'd100),
    FRAC_BITS'((ONE + 64'd500)      / 64'd1000),
    FRAC_BITS'((ONE + 64'd5000)     / 64'd10000),
    FRAC_BITS'((ONE + 64'd50000)    / 64'd100000),
    FRAC_BITS'((ONE + 64'd500000)   / 64'd1000000),
    FRAC_BITS'((ONE + 64'd5000000)  / 64'd10000000),
    FRAC_BITS'((ONE + 64'd50000000) / 64'd100000000)
  };
  localparam logic [3:0] DIGIT_LIMIT = 4'(MAX_INT_DIGITS);

  logic real_mode;

  // input register
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_start;

  // parse state
  dtnp_pkg::phase_t phase, phase_next;
  logic        neg, neg_next;
  logic [63:0] acc, acc_next;
  logic [3:0]  dcnt, dcnt_next;
  logic [3:0]  fidx, fidx_next;
  logic        ovf, ovf_next;

  // state as seen by this byte, after a string start clears it
  dtnp_pkg::phase_t ph0;
  logic        neg0;
  logic [63:0] acc0;
  logic [3:0]  dcnt0;
  logic [3:0]  fidx0;
  logic        ovf0;

  // arithmetic
  logic [3:0]            digit;
  logic [FRAC_BITS+3:0]  frac_add;
  logic [63:0]           add_val;
  logic [67:0]           acc_x10;
  logic [67:0]           sum;
  logic [63:0]           lim;
  logic                  clamp;
  logic [63:0]           acc_upd;
  logic                  ovf_upd;

  // emission
  logic              emit;
  logic              emit_inval;
  logic              emit_upd;     // limit stop: emit the just-updated magnitude
  dtnp_pkg::status_t emit_reason;
  logic [63:0]       e_acc;
  logic              e_ovf;
  logic              e_clamp;
  logic [63:0]       e_mag;
  logic [63:0]       e_value;
  dtnp_pkg::status_t e_status;

  logic out_free;
  logic fire;

  // ------------------------------------------------------------------------
  // Configuration register
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      real_mode <= 1'b0;
    end else if (cfg_we) begin
      real_mode <= cfg_wdata;
    end
  end

  // ------------------------------------------------------------------------
  // Input register: take a new transfer whenever the held byte moves on
  // ------------------------------------------------------------------------
  assign out_free = !m_tvalid || m_tready;
  assign fire     = in_valid && (!emit || out_free);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char  <= s_tdata;
      in_start <= s_tuser;
    end
  end

  // ------------------------------------------------------------------------
  // Apply string start before the byte is looked at
  // ------------------------------------------------------------------------
  always_comb begin
    if (in_start) begin
      ph0   = dtnp_pkg::PH_WS;
      neg0  = 1'b0;
      acc0  = '0;
      dcnt0 = '0;
      fidx0 = '0;
      ovf0  = 1'b0;
    end else begin
      ph0   = phase;
      neg0  = neg;
      acc0  = acc;
      dcnt0 = dcnt;
      fidx0 = fidx;
      ovf0  = ovf;
    end
  end

  // ------------------------------------------------------------------------
  // Accumulate: acc*10 + digit (integer part) or acc + digit*weight
  // (fraction part), clamped to the magnitude limit of the current mode.
  // acc*10 + add > lim is the same test as acc > (lim - add) / 10.
  // ------------------------------------------------------------------------
  assign digit    = in_char[3:0];
  assign frac_add = (FRAC_BITS+4)'(digit) * (FRAC_BITS+4)'(FRAC_W[fidx0[2:0]]);

  always_comb begin
    if (ph0 == dtnp_pkg::PH_FRAC) begin
      add_val = 64'(frac_add);
    end else if (real_mode) begin
      add_val = 64'(digit) << FRAC_BITS;
    end else begin
      add_val = 64'(digit);
    end
  end

  // 2^63-1 positive, 2^63 negative in real mode; 2^31-1 / 2^31 otherwise
  assign lim = real_mode ? {neg0, {63{!neg0}}}
                         : {32'd0, neg0, {31{!neg0}}};

  assign acc_x10 = (68'(acc0) << 3) + (68'(acc0) << 1);
  assign sum     = ((ph0 == dtnp_pkg::PH_FRAC) ? 68'(acc0) : acc_x10) + 68'(add_val);
  assign clamp   = sum > 68'(lim);
  assign acc_upd = clamp ? lim : sum[63:0];
  assign ovf_upd = ovf0 | clamp;

  // ------------------------------------------------------------------------
  // Byte classification and next parse state
  // ------------------------------------------------------------------------
  always_comb begin
    dtnp_pkg::phase_t ph;
    logic is_ws;
    logic is_digit;
    logic [3:0] dcnt_inc;

    is_ws    = (in_char == dtnp_pkg::CHAR_SPACE) ||
               ((in_char >= dtnp_pkg::CHAR_TAB) && (in_char <= dtnp_pkg::CHAR_CR));
    is_digit = (in_char >= dtnp_pkg::CHAR_0) && (in_char <= dtnp_pkg::CHAR_9);
    dcnt_inc = dcnt0 + 4'd1;

    ph          = ph0;
    phase_next  = ph0;
    neg_next    = neg0;
    acc_next    = acc0;
    dcnt_next   = dcnt0;
    fidx_next   = fidx0;
    ovf_next    = ovf0;
    emit        = 1'b0;
    emit_inval  = 1'b0;
    emit_upd    = 1'b0;
    emit_reason = dtnp_pkg::ST_END;

    if (ph0 == dtnp_pkg::PH_WS || ph0 == dtnp_pkg::PH_START ||
        ph0 == dtnp_pkg::PH_INT || ph0 == dtnp_pkg::PH_FRAC) begin
      if (ph0 == dtnp_pkg::PH_WS && is_ws) begin
        // skip leading whitespace
      end else begin
        if (ph0 == dtnp_pkg::PH_WS) begin
          ph         = dtnp_pkg::PH_START;
          phase_next = dtnp_pkg::PH_START;
        end
        if (in_char == dtnp_pkg::CHAR_NUL) begin
          emit        = 1'b1;
          emit_reason = dtnp_pkg::ST_END;
        end else if (in_char == dtnp_pkg::CHAR_PLUS || in_char == dtnp_pkg::CHAR_MINUS) begin
          if (ph != dtnp_pkg::PH_START) begin
            emit       = 1'b1;
            emit_inval = 1'b1;
          end else begin
            neg_next   = (in_char == dtnp_pkg::CHAR_MINUS);
            phase_next = dtnp_pkg::PH_INT;
          end
        end else if (in_char == dtnp_pkg::CHAR_DOT && real_mode) begin
          if (ph == dtnp_pkg::PH_FRAC) begin
            emit       = 1'b1;
            emit_inval = 1'b1;
          end else begin
            phase_next = dtnp_pkg::PH_FRAC;
          end
        end else if (is_digit) begin
          if (ph == dtnp_pkg::PH_FRAC) begin
            // digits past the eighth add nothing
            if (fidx0 < dtnp_pkg::FRAC_DIGITS) begin
              fidx_next = fidx0 + 4'd1;
              acc_next  = acc_upd;
              ovf_next  = ovf_upd;
            end
          end else begin
            phase_next = dtnp_pkg::PH_INT;
            acc_next   = acc_upd;
            ovf_next   = ovf_upd;
            if (!real_mode) begin
              dcnt_next = dcnt_inc;
              if (dcnt_inc >= DIGIT_LIMIT) begin
                emit        = 1'b1;
                emit_upd    = 1'b1;
                emit_reason = dtnp_pkg::ST_LIMIT;
              end
            end
          end
        end else begin
          emit        = 1'b1;
          emit_reason = dtnp_pkg::ST_OTHER;
        end
      end
    end

    if (emit) begin
      phase_next = dtnp_pkg::PH_DONE;
    end
  end

  // ------------------------------------------------------------------------
  // Result value: clamp once more to the current mode, then apply the sign
  // ------------------------------------------------------------------------
  assign e_acc   = emit_upd ? acc_upd : acc0;
  assign e_ovf   = emit_upd ? ovf_upd : ovf0;
  assign e_clamp = e_acc > lim;
  assign e_mag   = e_clamp ? lim : e_acc;

  always_comb begin
    if (emit_inval) begin
      e_value  = '0;
      e_status = dtnp_pkg::ST_INVALID;
    end else begin
      e_value  = neg0 ? (64'd0 - e_mag) : e_mag;
      e_status = (e_ovf || e_clamp) ? dtnp_pkg::ST_SAT : emit_reason;
    end
  end

  // ------------------------------------------------------------------------
  // Parse state registers: advance on every byte that leaves the input reg
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= dtnp_pkg::PH_WS;
      neg   <= 1'b0;
      acc   <= '0;
      dcnt  <= '0;
      fidx  <= '0;
      ovf   <= 1'b0;
    end else if (fire) begin
      phase <= phase_next;
      neg   <= neg_next;
      acc   <= acc_next;
      dcnt  <= dcnt_next;
      fidx  <= fidx_next;
      ovf   <= ovf_next;
    end
  end

  // ------------------------------------------------------------------------
  // Result register: load on an ending byte, drop once transferred
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      m_tdata <= e_value;
      m_tuser <= e_status;
    end
  end

endmodule

@@ design/dtnp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtnp_checker: port-level checks for the decimal text parser
// Watches the stream ports of the top level; bound to it below.
// ----------------------------------------------------------------------------
module dtnp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [2:0]  m_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // input back-pressure only comes from a blocked result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output back-pressure");

  // an invalid string always reports zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == dtnp_pkg::ST_INVALID |-> m_tdata == 64'd0)
    else $error("invalid status with non-zero value");

  // status codes stay within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= dtnp_pkg::ST_SAT)
    else $error("undefined status code");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind decimal_text_to_number_parser_core dtnp_checker u_dtnp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

@@ tb/sv/decimal_text_to_number_parser_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_text_to_number_parser_core_test: self-checking bench for the parser
// Streams text bytes into the parser with random gaps and result-side stalls,
// predicts every number and status from its own model of the parse state,
// and compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module decimal_text_to_number_parser_core_test;

  localparam int FRAC_BITS      = 24;
  localparam int MAX_INT_DIGITS = 10;
  localparam int TEXT_BYTES     = 1850;
  localparam int QUIET_LIMIT    = 2000;

  typedef struct {
    logic [63:0]       value;
    dtnp_pkg::status_t status;
  } number_result_t;

  // bit 8: string_start, bits 7:0: character
  typedef logic [8:0] text_byte_t;

  // Tracks the parse state byte by byte and queues the numbers it predicts.
  class number_scoreboard;
    logic             real_mode;
    dtnp_pkg::phase_t phase;
    logic             negative;
    logic [63:0]      magnitude;
    logic [3:0]       int_digits;
    logic [3:0]       frac_digits;
    logic             saturated;
    number_result_t   pending[$];
    int               failures;

    function new();
      real_mode = 1'b0;
      failures  = 0;
      clear();
    endfunction

    function void clear();
      phase       = dtnp_pkg::PH_WS;
      negative    = 1'b0;
      magnitude   = '0;
      int_digits  = '0;
      frac_digits = '0;
      saturated   = 1'b0;
    endfunction

    function logic [63:0] limit();
      logic [63:0] lim;
      lim = real_mode ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h0000_0000_7FFF_FFFF;
      return negative ? lim + 64'd1 : lim;
    endfunction

    // magnitude + add, or magnitude * 10 + add, clamped to the mode limit
    function void accumulate(logic [63:0] add, bit times_ten);
      logic [63:0] lim;
      lim = limit();
      if (add > lim) begin
        magnitude = lim;
        saturated = 1'b1;
      end else if (times_ten) begin
        if (magnitude > (lim - add) / 64'd10) begin
          magnitude = lim;
          saturated = 1'b1;
        end else begin
          magnitude = magnitude * 64'd10 + add;
        end
      end else if (magnitude > lim - add) begin
        magnitude = lim;
        saturated = 1'b1;
      end else begin
        magnitude = magnitude + add;
      end
    endfunction

    function void post(logic [63:0] value, dtnp_pkg::status_t status);
      number_result_t r;
      r.value  = value;
      r.status = status;
      pending.push_back(r);
      phase = dtnp_pkg::PH_DONE;
    endfunction

    // The limit of the current mode applies again at the end of the number.
    function void finish_number(dtnp_pkg::status_t why);
      logic [63:0] lim;
      lim = limit();
      if (magnitude > lim) begin
        magnitude = lim;
        saturated = 1'b1;
      end
      post(negative ? 64'd0 - magnitude : magnitude,
           saturated ? dtnp_pkg::ST_SAT : why);
    endfunction

    // Note one accepted byte; bytes after the end of a number are dropped.
    function void take_byte(logic [7:0] c, logic fresh);
      logic [63:0] d;
      logic [63:0] p;
      if (fresh)
        clear();
      if (phase == dtnp_pkg::PH_DONE)
        return;
      if (phase == dtnp_pkg::PH_WS) begin
        if (c == dtnp_pkg::CHAR_SPACE ||
            (c >= dtnp_pkg::CHAR_TAB && c <= dtnp_pkg::CHAR_CR))
          return;
        phase = dtnp_pkg::PH_START;
      end
      if (c == dtnp_pkg::CHAR_NUL) begin
        finish_number(dtnp_pkg::ST_END);
      end else if (c == dtnp_pkg::CHAR_PLUS || c == dtnp_pkg::CHAR_MINUS) begin
        if (phase != dtnp_pkg::PH_START) begin
          post(64'd0, dtnp_pkg::ST_INVALID);
        end else begin
          negative = (c == dtnp_pkg::CHAR_MINUS);
          phase    = dtnp_pkg::PH_INT;
        end
      end else if (c == dtnp_pkg::CHAR_DOT && real_mode) begin
        if (phase == dtnp_pkg::PH_FRAC)
          post(64'd0, dtnp_pkg::ST_INVALID);
        else
          phase = dtnp_pkg::PH_FRAC;
      end else if (c >= dtnp_pkg::CHAR_0 && c <= dtnp_pkg::CHAR_9) begin
        d = 64'(c - dtnp_pkg::CHAR_0);
        if (phase == dtnp_pkg::PH_FRAC) begin
          // weight of the k-th fraction digit: 2^FRAC_BITS / 10^k, rounded
          if (frac_digits < dtnp_pkg::FRAC_DIGITS) begin
            frac_digits = frac_digits + 4'd1;
            p = 64'd1;
            repeat (frac_digits) p = p * 64'd10;
            accumulate(d * (((64'd1 << FRAC_BITS) + p / 64'd2) / p), 1'b0);
          end
        end else begin
          phase = dtnp_pkg::PH_INT;
          if (real_mode) begin
            accumulate(d << FRAC_BITS, 1'b1);
          end else begin
            accumulate(d, 1'b1);
            int_digits = int_digits + 4'd1;
            if (int_digits >= MAX_INT_DIGITS)
              finish_number(dtnp_pkg::ST_LIMIT);
          end
        end
      end else begin
        finish_number(dtnp_pkg::ST_OTHER);
      end
    endfunction

    function void check_number(logic [63:0] value, logic [2:0] status);
      number_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, got value %0d status %0d",
                 $time, $signed(value), status);
        failures++;
        return;
      end
      want = pending.pop_front();
      if (value !== want.value) begin
        $display("%0t: number_value expected %0d, got %0d",
                 $time, $signed(want.value), $signed(value));
        failures++;
      end
      if (status !== want.status) begin
        $display("%0t: parse_status expected %0d, got %0d", $time, want.status, status);
        failures++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic [2:0]  m_tuser;

  number_scoreboard sb;
  text_byte_t       line_bytes[$];
  bit               calm;
  logic             mode_now;
  int               sent_bytes;
  int               quiet_cycles = 0;

  decimal_text_to_number_parser_core #(
    .FRAC_BITS      (FRAC_BITS),
    .MAX_INT_DIGITS (MAX_INT_DIGITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #1 clk = ~clk;

  // Gap before a transfer; none at all while a calm stretch lasts.
  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  // Present one byte after a random gap and hold it until the transfer.
  task automatic send_byte(input logic [7:0] c, input logic fresh);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tuser  <= fresh;
    do @(posedge clk); while (!s_tready);
    sb.take_byte(c, fresh);
    sent_bytes++;
  endtask

  task automatic send_chars(input string s, input logic fresh);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], (i == 0) ? fresh : 1'b0);
  endtask

  // Drop valid, drain every expected number, then let the pipeline empty.
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_mode(input logic v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    sb.real_mode = v;
    mode_now     = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void add(logic [7:0] c);
    line_bytes.push_back({1'b0, c});
  endfunction

  function automatic void add_digits(input string s);
    for (int i = 0; i < s.len(); i++)
      add(s[i]);
  endfunction

  function automatic logic [7:0] digit();
    return dtnp_pkg::CHAR_0 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] ws_char();
    int r;
    r = $urandom_range(0, 5);
    return (r == 0) ? dtnp_pkg::CHAR_SPACE : dtnp_pkg::CHAR_TAB + 8'(r - 1);
  endfunction

  // Build one piece of text: mostly well-formed numbers with random
  // content, the rest raw noise and bare whitespace or sign strings.
  function automatic void build_text();
    int kind;
    int sign;
    line_bytes.delete();
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      if ($urandom_range(0, 1) != 0)
        repeat ($urandom_range(1, 3)) add(ws_char());
      sign = $urandom_range(0, 2);
      if (sign == 1)
        add(dtnp_pkg::CHAR_PLUS);
      else if (sign == 2)
        add(dtnp_pkg::CHAR_MINUS);
      case ($urandom_range(0, 7))
        0: ;
        1, 2, 3: repeat ($urandom_range(1, 6)) add(digit());
        4: repeat ($urandom_range(8, 11)) add(digit());
        5: begin
          // right at the 32-bit edge
          add_digits("214748364");
          add(digit());
        end
        6: repeat ($urandom_range(11, 16)) add(digit());
        default: begin
          // right at the Q39.24 edge
          add_digits("54975581388");
          add(digit());
        end
      endcase
      if (mode_now ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 9) == 0)) begin
        add(dtnp_pkg::CHAR_DOT);
        repeat ($urandom_range(0, 11)) add(digit());
      end
      // a stray sign or second dot
      if ($urandom_range(0, 9) == 0)
        case ($urandom_range(0, 2))
          0: add(dtnp_pkg::CHAR_PLUS);
          1: add(dtnp_pkg::CHAR_MINUS);
          default: add(dtnp_pkg::CHAR_DOT);
        endcase
      case ($urandom_range(0, 3))
        0, 1: add(dtnp_pkg::CHAR_NUL);
        2: add(8'($urandom_range(0, 255)));
        default: ;
      endcase
      repeat ($urandom_range(0, 2)) add(8'($urandom_range(0, 255)));
    end else if (kind <= 8) begin
      repeat ($urandom_range(1, 8)) add(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 3)) add(ws_char());
      if ($urandom_range(0, 1) != 0)
        add(($urandom_range(0, 1) != 0) ? dtnp_pkg::CHAR_PLUS : dtnp_pkg::CHAR_MINUS);
      add(dtnp_pkg::CHAR_NUL);
    end
    // most strings restart the parse; a few continue the previous one
    if (line_bytes.size() != 0)
      line_bytes[0][8] = ($urandom_range(0, 7) != 0);
    if (line_bytes.size() > 2 && $urandom_range(0, 15) == 0)
      line_bytes[$urandom_range(1, line_bytes.size() - 1)][8] = 1'b1;
  endfunction

  // Result side: accept, check, then stall for a random gap, possibly none.
  initial begin : drain
    int stall;
    m_tready = 1'b1;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        sb.check_number(m_tdata, m_tuser);
        stall = draw_gap();
        if (stall != 0) begin
          @(negedge clk);
          m_tready <= 1'b0;
          repeat (stall) @(negedge clk);
          m_tready <= 1'b1;
        end
      end
    end
  end

  // Give up when no transfer happens on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    sb           = new();
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = 1'b0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = 1'b0;
    calm         = 1'b0;
    mode_now     = 1'b0;
    sent_bytes   = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Integer mode: whitespace and sign, sign after digits, bare whitespace,
    // dot as a terminator, then a byte that must be dropped after the end.
    set_mode(1'b0);
    send_chars("\t+7x", 1'b1);
    send_chars("5-", 1'b1);
    send_chars(" ", 1'b1);
    send_byte(dtnp_pkg::CHAR_NUL, 1'b0);
    send_chars("1.", 1'b1);
    send_byte(8'hFF, 1'b0);

    // Real mode: second dot, a plain fraction, then a large value finished
    // after a switch back to integer mode, which must saturate.
    settle();
    set_mode(1'b1);
    send_chars("-1.5.", 1'b1);
    send_chars("+.25", 1'b1);
    send_byte(dtnp_pkg::CHAR_NUL, 1'b0);
    send_chars("9999", 1'b1);
    settle();
    set_mode(1'b0);
    send_byte(dtnp_pkg::CHAR_NUL, 1'b0);

    sent_bytes = 0;
    while (sent_bytes < TEXT_BYTES) begin
      if ($urandom_range(0, 11) == 0) begin
        settle();
        set_mode(1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 7) == 0)
        calm = !calm;
      build_text();
      foreach (line_bytes[i])
        send_byte(line_bytes[i][7:0], line_bytes[i][8]);
    end

    settle();
    if (sb.failures == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
